@@ hdl/zrc_pkg.sv @@
package zrc_pkg;

  localparam int WORD_BYTES = 8;
  localparam int WORD_LSB   = $clog2(WORD_BYTES);

  localparam int DATA_W   = 64;
  localparam int STATUS_W = 2;
  localparam int CHUNK_W  = 31;
  localparam int ADDR_W   = 63;
  localparam int CFG_W    = 63;

  localparam logic [CHUNK_W-1:0] CHUNK_BYTES_RESET = CHUNK_W'(4096);

  // read status codes; anything else is handled as a read error
  localparam logic [STATUS_W-1:0] RS_FULL  = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] RS_SHORT = STATUS_W'(1);

  // configuration register indexes
  localparam logic [0:0] CFG_CHUNK_BYTES  = 1'b0;
  localparam logic [0:0] CFG_DEVICE_BYTES = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0]   data_word;
    logic                chunk_end;
    logic [STATUS_W-1:0] read_status;
  } zrc_in_t;

  typedef struct packed {
    logic              range_valid;
    logic [ADDR_W-1:0] range_start;
    logic [ADDR_W-1:0] range_length;
    logic              finished;
    logic              aborted;
    logic [ADDR_W-1:0] freed_total;
  } zrc_out_t;

  // decision for one chunk end, before length and total are worked out
  typedef struct packed {
    logic              range_valid;
    logic [ADDR_W-1:0] range_start;
    logic [ADDR_W-1:0] range_end;
    logic              finished;
    logic              aborted;
  } zrc_rec_t;

endpackage

@@ hdl/zrc_scan.sv @@
module zrc_scan (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  zrc_pkg::zrc_in_t             in_data,
  input  logic [zrc_pkg::CHUNK_W-1:0]  chunk_bytes,
  input  logic [zrc_pkg::ADDR_W-1:0]   device_bytes,
  output logic                         rec_valid,
  output zrc_pkg::zrc_rec_t            rec,
  input  logic                         rec_ready
);
  import zrc_pkg::*;

  logic              p0_v_r, p0_v_nxt;
  zrc_in_t           p0_r;
  logic [ADDR_W-1:0] chunk_offset_r, chunk_offset_nxt;
  logic              all_zero_r, all_zero_nxt;
  logic              range_open_r, range_open_nxt;
  logic [ADDR_W-1:0] open_start_r, open_start_nxt;
  logic              scan_done_r, scan_done_nxt;
  logic              p1_v_r, p1_v_nxt;
  zrc_rec_t          p1_r, p1_nxt;

  logic              acc_zero;
  logic              need_rec;
  logic              p1_free;
  logic              p0_fire;
  logic [ADDR_W:0]   next_end;
  logic              at_end;
  logic              last_chunk;
  logic [WORD_LSB-1:0] tail_lsb;
  logic              status_bad;
  logic              chunk_zero;
  zrc_rec_t          new_rec;

  always_comb begin
    acc_zero   = all_zero_r && (p0_r.data_word == '0);
    need_rec   = p0_r.chunk_end && !scan_done_r;
    p1_free    = !p1_v_r || rec_ready;
    p0_fire    = p0_v_r && (!need_rec || p1_free);
    in_stall   = p0_v_r && !p0_fire;
    next_end   = {1'b0, chunk_offset_r} + (ADDR_W+1)'(chunk_bytes);
    at_end     = chunk_offset_r >= device_bytes;
    last_chunk = next_end >= {1'b0, device_bytes};
    // only the low bits of the chunk length decide word alignment
    tail_lsb   = last_chunk ? (device_bytes[WORD_LSB-1:0] - chunk_offset_r[WORD_LSB-1:0])
                            : chunk_bytes[WORD_LSB-1:0];
    status_bad = (p0_r.read_status != RS_FULL) && (p0_r.read_status != RS_SHORT);
    chunk_zero = acc_zero && (p0_r.read_status == RS_FULL) && (tail_lsb == '0);
  end

  always_comb begin
    chunk_offset_nxt = chunk_offset_r;
    all_zero_nxt     = all_zero_r;
    range_open_nxt   = range_open_r;
    open_start_nxt   = open_start_r;
    scan_done_nxt    = scan_done_r;
    new_rec          = '0;
    if (p0_fire && !scan_done_r) begin
      if (!p0_r.chunk_end) begin
        all_zero_nxt = acc_zero;
      end else begin
        all_zero_nxt = 1'b1;
        if (status_bad) begin
          // drop any open range
          scan_done_nxt   = 1'b1;
          range_open_nxt  = 1'b0;
          new_rec.aborted = 1'b1;
        end else if (at_end) begin
          scan_done_nxt    = 1'b1;
          new_rec.finished = 1'b1;
          if (range_open_r) begin
            new_rec.range_valid = 1'b1;
            new_rec.range_start = open_start_r;
            new_rec.range_end   = chunk_offset_r;
            range_open_nxt      = 1'b0;
          end
        end else begin
          if (chunk_zero) begin
            if (!range_open_r) begin
              range_open_nxt = 1'b1;
              open_start_nxt = chunk_offset_r;
            end
            if (last_chunk) begin
              new_rec.range_valid = 1'b1;
              new_rec.range_start = range_open_r ? open_start_r : chunk_offset_r;
              new_rec.range_end   = device_bytes;
              range_open_nxt      = 1'b0;
            end
          end else if (range_open_r) begin
            new_rec.range_valid = 1'b1;
            new_rec.range_start = open_start_r;
            new_rec.range_end   = chunk_offset_r;
            range_open_nxt      = 1'b0;
          end
          if (last_chunk) begin
            scan_done_nxt    = 1'b1;
            new_rec.finished = 1'b1;
          end else begin
            chunk_offset_nxt = next_end[ADDR_W-1:0];
          end
        end
      end
    end
  end

  always_comb begin
    p0_v_nxt = in_stall ? p0_v_r : in_valid;
    p1_v_nxt = p1_v_r;
    p1_nxt   = p1_r;
    if (p0_fire && need_rec) begin
      p1_v_nxt = 1'b1;
      p1_nxt   = new_rec;
    end else if (rec_ready) begin
      p1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_v_r         <= 1'b0;
      chunk_offset_r <= '0;
      all_zero_r     <= 1'b1;
      range_open_r   <= 1'b0;
      open_start_r   <= '0;
      scan_done_r    <= 1'b0;
      p1_v_r         <= 1'b0;
    end else begin
      p0_v_r         <= p0_v_nxt;
      chunk_offset_r <= chunk_offset_nxt;
      all_zero_r     <= all_zero_nxt;
      range_open_r   <= range_open_nxt;
      open_start_r   <= open_start_nxt;
      scan_done_r    <= scan_done_nxt;
      p1_v_r         <= p1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      p0_r <= in_data;
    end
    p1_r <= p1_nxt;
  end

  assign rec_valid = p1_v_r;
  assign rec       = p1_r;

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    scan_done_r |=> scan_done_r)
    else $error("scan end cleared without reset");

  a_abort_no_range: assert property (@(posedge clk) disable iff (!rst_n)
    (p1_v_r && p1_r.aborted) |-> (!p1_r.range_valid && !p1_r.finished))
    else $error("aborted chunk carries a range or finish");

  a_open_order: assert property (@(posedge clk) disable iff (!rst_n)
    range_open_r |-> (open_start_r <= chunk_offset_r))
    else $error("open range starts past current chunk");

  a_rec_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (p1_v_r && !rec_ready) |=> (p1_v_r && $stable(p1_r)))
    else $error("pending chunk decision lost");

endmodule

@@ hdl/zrc_tally.sv @@
module zrc_tally (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rec_valid,
  input  zrc_pkg::zrc_rec_t  rec,
  output logic               rec_ready,
  output logic               out_valid,
  input  logic               out_stall,
  output zrc_pkg::zrc_out_t  out_data
);
  import zrc_pkg::*;

  logic              p2_v_r, p2_v_nxt;
  zrc_out_t          p2_r, p2_nxt;
  logic              out_v_r, out_v_nxt;
  zrc_out_t          out_r, out_nxt;
  logic [ADDR_W-1:0] freed_r, freed_nxt;
  logic              out_ready;

  always_comb begin
    out_ready = !out_v_r || !out_stall;
    rec_ready = !p2_v_r || out_ready;

    p2_v_nxt = rec_ready ? rec_valid : p2_v_r;
    p2_nxt   = p2_r;
    if (rec_valid && rec_ready) begin
      p2_nxt              = '0;
      p2_nxt.range_valid  = rec.range_valid;
      p2_nxt.range_start  = rec.range_valid ? rec.range_start : '0;
      p2_nxt.range_length = rec.range_valid ? (rec.range_end - rec.range_start) : '0;
      p2_nxt.finished     = rec.finished;
      p2_nxt.aborted      = rec.aborted;
    end

    out_v_nxt = out_ready ? p2_v_r : out_v_r;
    out_nxt   = out_r;
    freed_nxt = freed_r;
    if (p2_v_r && out_ready) begin
      freed_nxt           = freed_r + p2_r.range_length;
      out_nxt             = p2_r;
      out_nxt.freed_total = freed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      freed_r <= '0;
    end else begin
      p2_v_r  <= p2_v_nxt;
      out_v_r <= out_v_nxt;
      freed_r <= freed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p2_r  <= p2_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_total_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (p2_v_r && out_ready) |=> (out_r.freed_total == freed_r))
    else $error("reported total differs from running total");

  a_empty_range: assert property (@(posedge clk) disable iff (!rst_n)
    (p2_v_r && !p2_r.range_valid) |-> (p2_r.range_length == '0 && p2_r.range_start == '0))
    else $error("range fields set without a range");

  a_total_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(p2_v_r && out_ready) |=> $stable(freed_r))
    else $error("running total moved without a result");

endmodule

@@ hdl/zero_range_coalescer.sv @@
// Zero range coalescer: scans a device stream of 64-bit words and reports runs of
// all-zero chunks as byte ranges. A word can be accepted every clock unless a
// chunk-end word waits for the chunk decision register to free up. A chunk-end
// word is accepted into the input register and its result then passes the chunk
// decision, range length and result register with the running total. The chunk
// decision stage forms the next chunk offset by one add and two compares against
// the device size. Only chunk-end words produce a result. After the device end or
// a read error all words are consumed without effect until reset. Write
// chunk_bytes and device_bytes only while no transaction is in flight.
module zero_range_coalescer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  zrc_pkg::zrc_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output zrc_pkg::zrc_out_t          out_data,
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_index,
  input  logic [zrc_pkg::CFG_W-1:0]  cfg_wdata
);
  import zrc_pkg::*;

  logic [CHUNK_W-1:0] chunk_bytes_r, chunk_bytes_nxt;
  logic [ADDR_W-1:0]  device_bytes_r, device_bytes_nxt;
  logic               rec_valid;
  logic               rec_ready;
  zrc_rec_t           rec;

  always_comb begin
    chunk_bytes_nxt  = chunk_bytes_r;
    device_bytes_nxt = device_bytes_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_CHUNK_BYTES:  chunk_bytes_nxt  = cfg_wdata[CHUNK_W-1:0];
        CFG_DEVICE_BYTES: device_bytes_nxt = cfg_wdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_bytes_r  <= CHUNK_BYTES_RESET;
      device_bytes_r <= '0;
    end else begin
      chunk_bytes_r  <= chunk_bytes_nxt;
      device_bytes_r <= device_bytes_nxt;
    end
  end

  zrc_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .chunk_bytes  (chunk_bytes_r),
    .device_bytes (device_bytes_r),
    .rec_valid    (rec_valid),
    .rec          (rec),
    .rec_ready    (rec_ready)
  );

  zrc_tally u_tally (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_valid (rec_valid),
    .rec       (rec),
    .rec_ready (rec_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
